// ===== hdl/ctfp_pkg.sv =====
package ctfp_pkg;

  // Tree shape: LEVELS levels counting the leaf level.
  localparam int LEVELS     = 7;
  localparam int LEAF_W     = LEVELS - 1;
  localparam int CNT_W      = LEVELS;
  localparam int NODE_W     = LEVELS - 1;
  localparam int NUM_LEAVES = 1 << LEAF_W;
  localparam int NUM_BRANCH = NUM_LEAVES - 1;
  localparam int NUM_PAIRS  = NUM_LEAVES / 2;
  localparam int PAIR_W     = LEAF_W - 1;
  localparam int LVL_W      = $clog2(LEVELS);
  localparam int MODE_W     = 2;

  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 16;

  // Operation codes carried in the mode field.
  localparam logic [MODE_W-1:0] MODE_SET        = 2'd0;
  localparam logic [MODE_W-1:0] MODE_TAKE_ANY   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_TAKE_NAMED = 2'd2;

  // Deepest branch level that the walk visits.
  localparam logic [LVL_W-1:0] LAST_LVL = LVL_W'(LEVELS - 2);

  typedef struct packed {
    logic             start;   // item accepted: latch it and fetch the first child
    logic             step;    // walk one branch level
    logic             finish;  // update the leaf pair and load the result register
    logic [LVL_W-1:0] lvl;     // branch level being walked
  } ctfp_cmd_t;

  typedef struct packed {
    logic op_ok;     // the accepted item will change the tree
    logic out_free;  // the result register can take a new result
  } ctfp_status_t;

endpackage

// ===== hdl/counting_tree_flag_picker.sv =====
// A result is loaded into the result register in the leaf cycle, after the walk through the
// branch levels; a failing operation (leaf already set, leaf not set, empty tree, mode 3) skips the walk.
// A new item is taken only once the last one's leaf cycle is done; the walk does one
// counter read-modify-write per branch level through the counter store, then one leaf cycle.
// Reset (rst_n low, synchronous) clears every counter, every leaf flag and the
// result register at once; the first item may be sent the cycle after.
module counting_tree_flag_picker (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // in_tdata, from bit 0: mode[1:0], leaf[7:2], bias_bits[13:8], zero pad [15:14]
  input  logic [ctfp_pkg::IN_TDATA_W-1:0]     in_tdata,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // out_tdata, from bit 0: ok[0], leaf_out[6:1], full_res[7], set_count[14:8],
  // zero pad [15]
  output logic [ctfp_pkg::OUT_TDATA_W-1:0]    out_tdata
);

  // The controller sequences each item: it accepts in IDLE, walks the branch
  // levels from the root's children down to the lowest branch level, and
  // finishes in a leaf cycle that updates the leaf flags and the root count.
  // The datapath holds the counter store, the leaf flag pairs and the result
  // register. The block takes a new item while an earlier result still waits,
  // and only the leaf cycle waits for the result register to be free.

  localparam int LW = ctfp_pkg::LEAF_W;
  localparam int CW = ctfp_pkg::CNT_W;
  localparam int MW = ctfp_pkg::MODE_W;

  ctfp_pkg::ctfp_cmd_t    cmd;
  ctfp_pkg::ctfp_status_t st;

  logic [MW-1:0] in_mode;
  logic [LW-1:0] in_leaf;
  logic [LW-1:0] in_bias_bits;
  logic          out_ok;
  logic [LW-1:0] out_leaf_out;
  logic          out_full_res;
  logic [CW-1:0] out_set_count;

  // Unpack the input item; the pad bits carry nothing.
  assign in_mode      = in_tdata[MW-1:0];
  assign in_leaf      = in_tdata[MW+LW-1:MW];
  assign in_bias_bits = in_tdata[MW+2*LW-1:MW+LW];

  ctfp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .st        (st),
    .cmd       (cmd)
  );

  ctfp_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .st            (st),
    .in_mode       (in_mode),
    .in_leaf       (in_leaf),
    .in_bias_bits  (in_bias_bits),
    .out_tready    (out_tready),
    .out_valid     (out_tvalid),
    .out_ok        (out_ok),
    .out_leaf_out  (out_leaf_out),
    .out_full_res  (out_full_res),
    .out_set_count (out_set_count)
  );

  // Pack the result item, lowest field first, zero padded to whole bytes.
  assign out_tdata = {
    (ctfp_pkg::OUT_TDATA_W - 2 - LW - CW)'(0),
    out_set_count,
    out_full_res,
    out_leaf_out,
    out_ok
  };

endmodule

// ===== hdl/ctfp_ctrl.sv =====
module ctfp_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  ctfp_pkg::ctfp_status_t st,
  output ctfp_pkg::ctfp_cmd_t    cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_LEAF
  } state_t;

  state_t                      state_r;
  logic [ctfp_pkg::LVL_W-1:0] lvl_r;

  always_comb begin
    in_tready  = (state_r == S_IDLE);
    cmd.start  = in_tvalid && (state_r == S_IDLE);
    cmd.step   = (state_r == S_WALK);
    cmd.finish = (state_r == S_LEAF) && st.out_free;
    cmd.lvl    = lvl_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      lvl_r   <= ctfp_pkg::LVL_W'(1);
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (cmd.start) begin
            // A failing item touches no counter and goes straight to the result.
            state_r <= st.op_ok ? S_WALK : S_LEAF;
            lvl_r   <= ctfp_pkg::LVL_W'(1);
          end
        end
        S_WALK: begin
          if (lvl_r == ctfp_pkg::LAST_LVL) begin
            state_r <= S_LEAF;
          end else begin
            lvl_r <= lvl_r + ctfp_pkg::LVL_W'(1);
          end
        end
        S_LEAF: begin
          if (cmd.finish) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== hdl/ctfp_dp.sv =====
module ctfp_dp (
  input  logic                           clk,
  input  logic                           rst_n,
  input  ctfp_pkg::ctfp_cmd_t            cmd,
  output ctfp_pkg::ctfp_status_t         st,
  input  logic [ctfp_pkg::MODE_W-1:0]    in_mode,
  input  logic [ctfp_pkg::LEAF_W-1:0]    in_leaf,
  input  logic [ctfp_pkg::LEAF_W-1:0]    in_bias_bits,
  input  logic                           out_tready,
  output logic                           out_valid,
  output logic                           out_ok,
  output logic [ctfp_pkg::LEAF_W-1:0]    out_leaf_out,
  output logic                           out_full_res,
  output logic [ctfp_pkg::CNT_W-1:0]     out_set_count
);

  localparam int NW = ctfp_pkg::NODE_W;
  localparam int CW = ctfp_pkg::CNT_W;
  localparam int LW = ctfp_pkg::LEAF_W;
  localparam int PW = ctfp_pkg::PAIR_W;
  localparam int VW = ctfp_pkg::LVL_W;

  // Branch counter store, heap order; entry 0 (root) lives in root_r instead.
  logic [CW-1:0] branch_mem_r [ctfp_pkg::NUM_BRANCH];
  logic          branch_vld_r [ctfp_pkg::NUM_BRANCH];
  logic [CW-1:0] rdata_r;

  // Leaf flags kept as pairs, one row per lowest branch node.
  logic [1:0]    pair_r [ctfp_pkg::NUM_PAIRS];

  logic [CW-1:0]                   root_r;
  logic [CW-1:0]                   root_nxt;
  logic [ctfp_pkg::MODE_W-1:0]     mode_r;
  logic [LW-1:0]                   leaf_r;
  logic [LW-1:0]                   bias_r;
  logic                            ok_r;
  logic [NW-1:0]                   cur_node_r;
  logic [CW-1:0]                   cur_cnt_r;
  logic [PW-1:0]                   path_r;
  logic                            out_valid_r;
  logic                            out_ok_r;
  logic [LW-1:0]                   out_leaf_r;
  logic                            out_full_r;
  logic [CW-1:0]                   out_cnt_r;

  logic          is_any;
  logic          is_set;
  logic [LW-1:0] dir_sel;
  logic          in_dir;
  logic          cur_dir;
  logic          next_dir;
  logic          swap;
  logic          step_bit;
  logic [NW:0]   step_child;
  logic [NW-1:0] step_node;
  logic [CW-1:0] step_cnt;
  logic [CW-1:0] wdata;
  logic          ren;
  logic [NW:0]   raddr_wide;
  logic [NW-1:0] raddr;
  logic [PW-1:0] pair_addr;
  logic [1:0]    pair_rd;
  logic          in_flag;
  logic          leaf_dir;
  logic          pick;
  logic [LW-1:0] taken;
  logic [VW-1:0] cur_idx;
  logic [VW-1:0] next_idx;

  assign is_any  = (mode_r == ctfp_pkg::MODE_TAKE_ANY);
  assign is_set  = (mode_r == ctfp_pkg::MODE_SET);
  assign dir_sel = is_any ? bias_r : leaf_r;
  assign in_dir  = (in_mode == ctfp_pkg::MODE_TAKE_ANY) ? in_bias_bits[LW-1] : in_leaf[LW-1];

  // Level d is steered by bit LEAF_W-d; the next level by the bit below it.
  assign cur_idx  = VW'(LW) - cmd.lvl;
  assign next_idx = VW'(LW - 1) - cmd.lvl;
  assign cur_dir  = dir_sel[cur_idx];
  assign next_dir = dir_sel[next_idx];

  // The preferred child was fetched last cycle. When it is empty, the other
  // child holds every set leaf of the parent, so its count is the parent's.
  assign swap       = is_any && (rdata_r == '0);
  assign step_bit   = cur_dir ^ swap;
  assign step_child = {cur_node_r, 1'b0} + (NW+1)'(1) + (NW+1)'(step_bit);
  assign step_node  = step_child[NW-1:0];
  assign step_cnt   = swap ? cur_cnt_r : rdata_r;
  assign wdata      = is_set ? step_cnt + CW'(1) : step_cnt - CW'(1);

  always_comb begin
    ren        = 1'b0;
    raddr_wide = '0;
    if (cmd.start) begin
      ren        = 1'b1;
      raddr_wide = (NW+1)'(1) + (NW+1)'(in_dir);
    end else if (cmd.step && (cmd.lvl != ctfp_pkg::LAST_LVL)) begin
      ren        = 1'b1;
      raddr_wide = {step_node, 1'b0} + (NW+1)'(1) + (NW+1)'(next_dir);
    end
  end
  assign raddr = raddr_wide[NW-1:0];

  // One pair read per cycle: the named leaf at accept, the walked pair at finish.
  assign pair_addr = cmd.start ? in_leaf[LW-1:1] : path_r;
  assign pair_rd   = pair_r[pair_addr];
  assign in_flag   = pair_rd[in_leaf[0]];

  always_comb begin
    unique case (in_mode)
      ctfp_pkg::MODE_SET:        st.op_ok = !in_flag;
      ctfp_pkg::MODE_TAKE_ANY:   st.op_ok = (root_r != '0);
      ctfp_pkg::MODE_TAKE_NAMED: st.op_ok = in_flag;
      default:                   st.op_ok = 1'b0;
    endcase
  end
  assign st.out_free = !out_valid_r || out_tready;

  assign leaf_dir = dir_sel[0];
  assign pick     = is_any ? (pair_rd[leaf_dir] ? leaf_dir : !leaf_dir) : leaf_dir;
  assign taken    = {path_r, pick};
  assign root_nxt = is_set ? root_r + CW'(1) : root_r - CW'(1);

  // Counter store: one read and one write per cycle, read data registered.
  always_ff @(posedge clk) begin
    if (ren) begin
      rdata_r <= branch_vld_r[raddr] ? branch_mem_r[raddr] : '0;
    end
    if (cmd.step) begin
      branch_mem_r[step_node] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < ctfp_pkg::NUM_BRANCH; i++) begin
        branch_vld_r[i] <= 1'b0;
      end
    end else if (cmd.step) begin
      branch_vld_r[step_node] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < ctfp_pkg::NUM_PAIRS; i++) begin
        pair_r[i] <= 2'b00;
      end
      root_r <= '0;
    end else if (cmd.finish && ok_r) begin
      pair_r[path_r][pick] <= is_set;
      root_r               <= root_nxt;
    end
  end

  // Item registers and walk position.
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      mode_r     <= in_mode;
      leaf_r     <= in_leaf;
      bias_r     <= in_bias_bits;
      ok_r       <= st.op_ok;
      cur_node_r <= '0;
      cur_cnt_r  <= root_r;
    end else if (cmd.step) begin
      cur_node_r <= step_node;
      cur_cnt_r  <= step_cnt;
      path_r     <= {path_r[PW-2:0], step_bit};
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.finish) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_ok_r   <= ok_r;
      out_leaf_r <= (ok_r && is_any) ? taken : '0;
      if (ok_r) begin
        out_cnt_r  <= root_nxt;
        out_full_r <= (root_nxt == CW'(ctfp_pkg::NUM_LEAVES));
      end else begin
        out_cnt_r  <= root_r;
        out_full_r <= (root_r == CW'(ctfp_pkg::NUM_LEAVES));
      end
    end
  end

  assign out_valid     = out_valid_r;
  assign out_ok        = out_ok_r;
  assign out_leaf_out  = out_leaf_r;
  assign out_full_res  = out_full_r;
  assign out_set_count = out_cnt_r;

endmodule

// ===== hdl/ctfp_checker.sv =====
module ctfp_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tvalid,
  input logic                             in_tready,
  input logic [ctfp_pkg::IN_TDATA_W-1:0]  in_tdata,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [ctfp_pkg::OUT_TDATA_W-1:0] out_tdata
);

  logic       res_ok;
  logic [5:0] res_leaf;
  logic       res_full;
  logic [6:0] res_cnt;

  assign res_ok   = out_tdata[0];
  assign res_leaf = out_tdata[6:1];
  assign res_full = out_tdata[7];
  assign res_cnt  = out_tdata[14:8];

  // A held result keeps its contents until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // Items are worked one at a time: after an accept the input is closed.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted again during an operation");

  // The root count never exceeds the number of leaves.
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> res_cnt <= 7'(ctfp_pkg::NUM_LEAVES))
    else $error("set count beyond leaf count");

  // The full flag agrees with the reported count.
  a_full_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> res_full == (res_cnt == 7'(ctfp_pkg::NUM_LEAVES)))
    else $error("full flag disagrees with set count");

  // A failed operation never reports a taken leaf.
  a_fail_leaf: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !res_ok |-> res_leaf == '0)
    else $error("failed operation reports a leaf");

endmodule

bind counting_tree_flag_picker ctfp_checker u_ctfp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
